FILE: rtl/core/rth_pkg.sv
// shared constants, types and lane layout for the rgb to hsv/hsl converter
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

  // pixel and result widths
  localparam int PIX_W  = 8;
  localparam int HUE_W  = 9;
  localparam int FRAC_W = 16;

  // divider lanes, both run in lock step
  localparam int LANES    = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // fraction scaling: round(num * 2^16 / den) = (num * 2^17 + den) / (2 * den)
  localparam int FRAC_SHIFT = FRAC_W + 1;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int NUM_W      = 26;
  localparam int DEN_W      = 10;

  // front stages, divider stages, output stage
  localparam int PIPE_LAT = QUO_W + 3;

  // constant divisors and hue wrap
  localparam int LVL_DEN_HSV = 255;
  localparam int LVL_DEN_HSL = 510;
  localparam int HUE_FULL    = 360;

  // output_space codes
  localparam logic SPACE_HSV = 1'b0;
  localparam logic SPACE_HSL = 1'b1;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // flags and the level code, which rides along beside the divider
  typedef struct packed {
    logic             neg;
    logic             hue_zero;
    logic             sat_zero;
    logic [QUO_W-1:0] lvl;
  } side_t;

  typedef logic [LANES-1:0][NUM_W-1:0] num_lanes_t;
  typedef logic [LANES-1:0][DEN_W-1:0] den_lanes_t;
  typedef logic [LANES-1:0][QUO_W-1:0] quo_lanes_t;

endpackage

`default_nettype wire

FILE: rtl/core/rth_front.sv
// front stages: max/min and sector, then dividend and divisor for each lane, and level
`timescale 1ns / 1ps
`default_nettype none

module rth_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [rth_pkg::PIX_W-1:0]      red,
  input  wire logic [rth_pkg::PIX_W-1:0]      green,
  input  wire logic [rth_pkg::PIX_W-1:0]      blue,
  input  wire logic                           output_space,
  output logic                                out_valid,
  output rth_pkg::num_lanes_t                 out_num,
  output rth_pkg::den_lanes_t                 out_den,
  output rth_pkg::side_t                      out_side
);

  // stage 1 registers
  logic                              s1_vld;
  logic [rth_pkg::PIX_W-1:0]         s1_mx;
  logic [rth_pkg::PIX_W-1:0]         s1_mn;
  rth_pkg::sector_t                  s1_sect;
  logic signed [rth_pkg::PIX_W:0]    s1_x;

  // stage 1 logic
  logic [rth_pkg::PIX_W-1:0]         mx0, mn0, mx_next, mn_next;
  rth_pkg::sector_t                  sect_next;
  logic signed [rth_pkg::PIX_W:0]    x_next;
  logic                              r_gt_g;

  always_comb begin
    r_gt_g = red > green;
    mx0    = r_gt_g ? red : green;
    mn0    = r_gt_g ? green : red;
    if (blue > mx0) begin
      mx_next = blue;
      mn_next = mn0;
    end else begin
      mx_next = mx0;
      mn_next = (blue < mn0) ? blue : mn0;
    end
    // ties favor red, then green
    if (mx_next == red) begin
      sect_next = rth_pkg::SECT_RED;
      x_next    = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (mx_next == green) begin
      sect_next = rth_pkg::SECT_GREEN;
      x_next    = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sect_next = rth_pkg::SECT_BLUE;
      x_next    = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
    end
    s1_mx   <= mx_next;
    s1_mn   <= mn_next;
    s1_sect <= sect_next;
    s1_x    <= x_next;
  end

  // stage 2 logic
  localparam int NT_W = 18;

  logic [rth_pkg::PIX_W-1:0]         d;
  logic signed [NT_W-1:0]            xe, de, d120, offs, ntot, nabs;
  logic [NT_W-1:0]                   hue_num;
  logic [rth_pkg::PIX_W:0]           s2;
  logic [rth_pkg::PIX_W-1:0]         dev, hsl_den, sat_den;
  logic [rth_pkg::QUO_W-1:0]         lvl_next;
  rth_pkg::num_lanes_t               num_next;
  rth_pkg::den_lanes_t               den_next;
  rth_pkg::side_t                    side_next;

  always_comb begin
    d    = s1_mx - s1_mn;
    xe   = NT_W'(s1_x);
    de   = NT_W'(d);
    d120 = (de <<< 7) - (de <<< 3);
    case (s1_sect)
      rth_pkg::SECT_RED:   offs = '0;
      rth_pkg::SECT_GREEN: offs = d120;
      rth_pkg::SECT_BLUE:  offs = d120 <<< 1;
      default:             offs = '0;
    endcase
    // 60*x plus sector offset, then 2*|n| + d for round half away
    ntot    = (xe <<< 6) - (xe <<< 2) + offs;
    nabs    = ntot[NT_W-1] ? -ntot : ntot;
    hue_num = {nabs[NT_W-2:0], 1'b0} + NT_W'(d);

    s2      = {1'b0, s1_mx} + {1'b0, s1_mn};
    dev     = (s2 >= (rth_pkg::PIX_W+1)'(rth_pkg::LVL_DEN_HSV))
              ? rth_pkg::PIX_W'(s2 - (rth_pkg::PIX_W+1)'(rth_pkg::LVL_DEN_HSV))
              : rth_pkg::PIX_W'((rth_pkg::PIX_W+1)'(rth_pkg::LVL_DEN_HSV) - s2);
    hsl_den = rth_pkg::PIX_W'(rth_pkg::LVL_DEN_HSV) - dev;

    if (output_space == rth_pkg::SPACE_HSL) begin
      sat_den            = hsl_den;
      side_next.sat_zero = (d == '0);
      // s2/510 rounded: 128*s2 + s2/2, plus one for odd sums or the upper half
      lvl_next = rth_pkg::QUO_W'({s2, 7'b0}) + rth_pkg::QUO_W'(s2[rth_pkg::PIX_W:1])
                 + rth_pkg::QUO_W'(s2[0] | s2[rth_pkg::PIX_W]);
    end else begin
      sat_den            = s1_mx;
      side_next.sat_zero = (s1_mx == '0);
      // mx/255 rounded: 257*mx, plus one for the upper half
      lvl_next = rth_pkg::QUO_W'({s1_mx, s1_mx})
                 + rth_pkg::QUO_W'(s1_mx[rth_pkg::PIX_W-1]);
    end
    side_next.neg      = ntot[NT_W-1];
    side_next.hue_zero = (d == '0);
    side_next.lvl      = lvl_next;

    num_next[rth_pkg::LANE_HUE] = rth_pkg::NUM_W'(hue_num);
    den_next[rth_pkg::LANE_HUE] = rth_pkg::DEN_W'({d, 1'b0});
    num_next[rth_pkg::LANE_SAT] = (rth_pkg::NUM_W'(d) << rth_pkg::FRAC_SHIFT)
                                  + rth_pkg::NUM_W'(sat_den);
    den_next[rth_pkg::LANE_SAT] = rth_pkg::DEN_W'({sat_den, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_vld;
    end
    out_num  <= num_next;
    out_den  <= den_next;
    out_side <= side_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rth_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes in lock step
`timescale 1ns / 1ps
`default_nettype none

module rth_div #(
  parameter int LANES = rth_pkg::LANES,
  parameter int NW    = rth_pkg::NUM_W,
  parameter int DW    = rth_pkg::DEN_W,
  parameter int QW    = rth_pkg::QUO_W,
  parameter int SW    = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic [LANES-1:0][NW-1:0]         in_num,
  input  wire logic [LANES-1:0][DW-1:0]         in_den,
  input  wire logic [SW-1:0]                    in_side,
  output logic                                  out_valid,
  output logic [LANES-1:0][QW-1:0]              out_quo,
  output logic [SW-1:0]                         out_side
);

  // dividend bits above the quotient must already be below the divisor
  logic                          vld  [QW];
  logic [SW-1:0]                 side [QW];
  logic [LANES-1:0][QW-1:0]      acc  [QW];
  logic [LANES-1:0][DW-1:0]      rem  [QW-1];
  logic [LANES-1:0][DW-1:0]      dens [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                        vld_in;
    logic [SW-1:0]               side_in;
    logic [LANES-1:0][DW-1:0]    rem_in, den_in, rem_next;
    logic [LANES-1:0][QW-1:0]    acc_in, acc_next;

    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = in_valid;
        side_in = in_side;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DW'(in_num[l][NW-1:QW]);
          acc_in[l] = in_num[l][QW-1:0];
          den_in[l] = in_den[l];
        end
      end
    end else begin : g_rest
      assign vld_in  = vld[s-1];
      assign side_in = side[s-1];
      assign rem_in  = rem[s-1];
      assign acc_in  = acc[s-1];
      assign den_in  = dens[s-1];
    end

    always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        trial       = {rem_in[l], acc_in[l][QW-1]};
        ge          = trial >= {1'b0, den_in[l]};
        rem_next[l] = ge ? DW'(trial - {1'b0, den_in[l]}) : DW'(trial);
        acc_next[l] = {acc_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
      side[s] <= side_in;
      acc[s]  <= acc_next;
    end

    if (s < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[s]  <= rem_next;
        dens[s] <= den_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = acc[QW-1];
  assign out_side  = side[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/rth_back.sv
// output stage: hue sign and wrap, fraction clamp, result registers
`timescale 1ns / 1ps
`default_nettype none

module rth_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire rth_pkg::quo_lanes_t              in_quo,
  input  wire rth_pkg::side_t                   in_side,
  output logic                                  done,
  output logic [rth_pkg::HUE_W-1:0]             hue,
  output logic [rth_pkg::FRAC_W-1:0]            saturation,
  output logic [rth_pkg::FRAC_W-1:0]            level
);

  logic [rth_pkg::HUE_W-1:0]      hq, hue_next;
  logic [rth_pkg::QUO_W-1:0]      sq, lq;
  logic [rth_pkg::FRAC_W-1:0]     sat_next, lvl_next;

  always_comb begin
    hq = in_quo[rth_pkg::LANE_HUE][rth_pkg::HUE_W-1:0];
    sq = in_quo[rth_pkg::LANE_SAT];
    lq = in_side.lvl;
    if (in_side.hue_zero) begin
      hue_next = '0;
    end else if (in_side.neg && (hq != '0)) begin
      hue_next = rth_pkg::HUE_W'(rth_pkg::HUE_FULL) - hq;
    end else begin
      hue_next = hq;
    end
    // a quotient of exactly 1.0 saturates
    if (in_side.sat_zero) begin
      sat_next = '0;
    end else begin
      sat_next = sq[rth_pkg::QUO_W-1] ? '1 : sq[rth_pkg::FRAC_W-1:0];
    end
    lvl_next = lq[rth_pkg::QUO_W-1] ? '1 : lq[rth_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    hue        <= hue_next;
    saturation <= sat_next;
    level      <= lvl_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_to_hsv_hsl.sv
// top level of the rgb to hsv/hsl pixel converter
//
//   channel   signals                               direction  accepted when
//   pixel     start, busy, red, green, blue         in         start && !busy
//   result    done, hue, saturation, level          out        every cycle done is high
//   config    cfg_valid, cfg_ready, cfg_data        in         cfg_valid && cfg_ready
//
// one pixel per clock, results appear in the order the pixels are taken
// latency is set by the 17-stage restoring divider plus two front stages and
// one output stage; hue and saturation quotients run in parallel lanes, level is
// a constant scaling done in the front and rides along with the flags
// busy is always low: the receiver takes each result as it comes, so nothing stalls
// rst is synchronous: it clears all valid bits and sets output_space to hsv
// output_space is to be written only while no pixel is in flight
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_hsl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // pixel transaction
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [rth_pkg::PIX_W-1:0]        red,
  input  wire logic [rth_pkg::PIX_W-1:0]        green,
  input  wire logic [rth_pkg::PIX_W-1:0]        blue,
  // result transaction
  output logic                                  done,
  output logic [rth_pkg::HUE_W-1:0]             hue,
  output logic [rth_pkg::FRAC_W-1:0]            saturation,
  output logic [rth_pkg::FRAC_W-1:0]            level,
  // output_space register write
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_data
);

  // output_space: 0 for hsv, 1 for hsl
  logic                         output_space;
  logic                         in_valid;

  // front to divider
  logic                         fr_valid;
  rth_pkg::num_lanes_t          fr_num;
  rth_pkg::den_lanes_t          fr_den;
  rth_pkg::side_t               fr_side;

  // divider to output stage
  logic                         dv_valid;
  rth_pkg::quo_lanes_t          dv_quo;
  logic [$bits(rth_pkg::side_t)-1:0] dv_side;

  // fully pipelined, never holds off a pixel or a register write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_space <= rth_pkg::SPACE_HSV;
    end else if (cfg_valid && cfg_ready) begin
      output_space <= cfg_data;
    end
  end

  // max, min, hue sector, then dividends and divisors for hue and saturation, and level
  rth_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .output_space (output_space),
    .out_valid    (fr_valid),
    .out_num      (fr_num),
    .out_den      (fr_den),
    .out_side     (fr_side)
  );

  // two rounded divisions side by side, flags and level ride along
  rth_div #(
    .LANES (rth_pkg::LANES),
    .NW    (rth_pkg::NUM_W),
    .DW    (rth_pkg::DEN_W),
    .QW    (rth_pkg::QUO_W),
    .SW    ($bits(rth_pkg::side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   (fr_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // grey and black cases, negative hue wrap, clamp of 1.0
  rth_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv_valid),
    .in_quo     (dv_quo),
    .in_side    (rth_pkg::side_t'(dv_side)),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .level      (level)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rth_checker.sv
// port-level checks for the converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rth_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             busy,
  input  wire logic                             done,
  input  wire logic [rth_pkg::HUE_W-1:0]        hue
);

  localparam int LAT = rth_pkg::PIPE_LAT;

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // every accepted pixel gives a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted pixel gave no result");

  // no result without a pixel taken the same latency earlier
  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching pixel");

  // hue never reaches a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < rth_pkg::HUE_W'(rth_pkg::HUE_FULL)))
    else $error("hue out of range");

endmodule

bind rgb_to_hsv_hsl rth_checker u_chk (.*);

`default_nettype wire
